### rtl/flow_vector_sigma_clip_macros.svh
// assertion macros for the flow vector sigma clip block
`ifndef FLOW_VECTOR_SIGMA_CLIP_MACROS_SVH
`define FLOW_VECTOR_SIGMA_CLIP_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define FVSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define FVSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fvsc_pkg.sv
// ----------------------------------------------------------------------------
// fvsc_pkg
// types, codes and constants shared by the sigma clip block
// ----------------------------------------------------------------------------
package fvsc_pkg;

  localparam int MaxFeaturesDefault = 512;
  localparam int FracBitsDefault    = 4;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_FETCH  = 2'd2;

  localparam logic [1:0] KIND_STATS = 2'd0;
  localparam logic [1:0] KIND_KEPT  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] disp_x;
    logic signed [15:0] disp_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        mean_mag;
    logic [15:0]        std_mag;
    logic [17:0]        clip_level;
    logic [9:0]         total_count;
    logic [9:0]         kept_count;
    logic               overflowed;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [15:0]        out_mag;
  } out_item_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NOP     = 4'd0,
    CMD_LOAD    = 4'd1,  // start root of new vector
    CMD_SUM_CLR = 4'd2,  // clear accumulators, index
    CMD_SUM     = 4'd3,  // accumulate one magnitude
    CMD_DIV1    = 4'd4,  // start mean division
    CMD_DEV     = 4'd5,  // accumulate one squared deviation
    CMD_DIV2    = 4'd6,  // start variance division
    CMD_ROOT    = 4'd7,  // start std root
    CMD_THR     = 4'd8,  // form threshold, clear index
    CMD_KEEP    = 4'd9,  // count one kept
    CMD_REPORT  = 4'd10, // emit stats
    CMD_FSCAN   = 4'd11, // examine one entry at fetch pointer
    CMD_FNONE   = 4'd12  // emit none-left
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t code;
    logic      new_set;  // load after finish
  } dp_cmd_t;

  typedef struct packed {
    logic unit_busy;   // divider or root running, or store or mean pending
    logic idx_last;    // walk index at last entry
    logic empty;       // load count zero
    logic finished;
    logic fetch_end;   // fetch pointer at load count
    logic fetch_hit;   // read entry is kept
    logic rd_valid;    // read data registered for a walk or scan
  } dp_stat_t;

endpackage

### rtl/fvsc_isqrt.sv
// ----------------------------------------------------------------------------
// fvsc_isqrt
// bit-pair iterative floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module fvsc_isqrt #(
  parameter int W = 40
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  logic [W-1:0]   value,
  output logic           busy,
  output logic [W/2-1:0] root
);
  localparam int RW = W / 2;
  localparam int CW = $clog2(RW + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  src;
  logic [RW-1:0] q;
  logic [CW-1:0] cnt;
  logic [RW+1:0] trial;
  logic [RW+1:0] part;

  assign part  = {rem[RW-1:0], src[W-1:W-2]};
  assign trial = {q, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= CW'(RW);
      rem  <= '0;
      q    <= '0;
      src  <= value;
    end else if (busy) begin
      src <= {src[W-3:0], 2'b00};
      if (part >= trial) begin
        rem <= W'(part - trial);
        q   <= {q[RW-2:0], 1'b1};
      end else begin
        rem <= W'(part);
        q   <= {q[RW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  assign root = q;
endmodule

### rtl/fvsc_div.sv
// ----------------------------------------------------------------------------
// fvsc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fvsc_div #(
  parameter int NW = 40,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [DW:0]   rem;
  logic [NW-1:0] n;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic [DW:0]   sh;

  assign sh = {rem[DW-1:0], n[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      rem  <= '0;
      n    <= num;
      d    <= den;
    end else if (busy) begin
      n <= {n[NW-2:0], 1'b0};
      if (sh >= {1'b0, d}) begin
        rem <= sh - {1'b0, d};
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= sh;
        quo <= {quo[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end
endmodule

### rtl/fvsc_datapath.sv
// ----------------------------------------------------------------------------
// fvsc_datapath
// feature stores, accumulators, divide and root units, result register
// ----------------------------------------------------------------------------
module fvsc_datapath #(
  parameter int MAX_FEATURES = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  fvsc_pkg::in_item_t item,
  input  fvsc_pkg::dp_cmd_t  cmd,
  output fvsc_pkg::dp_stat_t stat,
  output logic              done,
  output fvsc_pkg::out_item_t result
);
  import fvsc_pkg::*;

  localparam int AW  = $clog2(MAX_FEATURES);
  localparam int CW  = $clog2(MAX_FEATURES + 1);
  localparam int SW  = 16 + CW;       // magnitude sum
  localparam int VW  = 32 + CW;       // squared deviation sum
  localparam int RVW = VW + (VW % 2); // std root input, even width

  logic [31:0] vec_mem [MAX_FEATURES];
  logic [15:0] mag_mem [MAX_FEATURES];

  logic [CW-1:0] load_count;
  logic [CW-1:0] fetch_ptr;
  logic [CW-1:0] idx;
  logic [CW-1:0] kept;
  logic [17:0]   thr;
  logic          finished;
  logic          ovf;
  logic [SW-1:0] sum;
  logic [VW-1:0] dev;
  logic [15:0]   mean;
  logic [15:0]   stdv;

  // root of incoming vector, stored when done
  logic [31:0] pend_vec;
  logic        pend;
  logic signed [31:0] sx;
  logic signed [31:0] sy;
  logic [32:0] sq_in;
  logic        r1_busy;
  logic [16:0] r1_root;

  logic [31:0] rd_vec;
  logic [15:0] rd_mag;
  logic        rd_valid;
  logic        rd_keep;
  logic        rd_scan;
  logic [AW-1:0] rd_addr;

  logic        div_go, div_busy;
  logic [VW-1:0] div_num;
  logic [VW-1:0] div_quo;
  logic        r2_go, r2_busy;
  logic [VW-1:0] r2_val;
  logic [RVW/2-1:0] r2_root;
  logic        div_mean;
  logic [15:0] sd_now;

  logic [15:0] dabs;
  logic [31:0] dsq;

  logic        scan_hit;
  logic        done_next;
  out_item_t   res_next;

  assign sx    = 32'(item.disp_x);
  assign sy    = 32'(item.disp_y);
  assign sq_in = 33'(sx * sx) + 33'(sy * sy);

  fvsc_isqrt #(.W(34)) u_mag_root (
    .clk(clk), .rst(rst), .go(cmd.code == CMD_LOAD), .value({1'b0, sq_in}),
    .busy(r1_busy), .root(r1_root)
  );

  // the last registered read is folded in as the divide starts
  assign div_go  = (cmd.code == CMD_DIV1) || (cmd.code == CMD_DIV2);
  assign div_num = (cmd.code == CMD_DIV1) ? VW'(sum) + VW'(rd_mag) : dev + VW'(dsq);

  fvsc_div #(.NW(VW), .DW(CW)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(div_num), .den(load_count),
    .busy(div_busy), .quo(div_quo)
  );

  assign r2_go  = (cmd.code == CMD_ROOT);
  assign r2_val = div_quo;

  fvsc_isqrt #(.W(RVW)) u_std_root (
    .clk(clk), .rst(rst), .go(r2_go), .value(RVW'(r2_val)),
    .busy(r2_busy), .root(r2_root)
  );

  // empty set keeps a zero std
  assign sd_now = (load_count == '0) ? 16'd0 : r2_root[15:0];

  // walk read address: fetch uses its pointer, statistics use the index
  assign rd_addr = (cmd.code == CMD_FSCAN) ? fetch_ptr[AW-1:0] : idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (pend && !r1_busy) begin
      vec_mem[load_count[AW-1:0]] <= pend_vec;
      mag_mem[load_count[AW-1:0]] <= r1_root[15:0];
    end
    rd_vec <= vec_mem[rd_addr];
    rd_mag <= mag_mem[rd_addr];
  end

  assign dabs = (rd_mag >= mean) ? rd_mag - mean : mean - rd_mag;
  assign dsq  = dabs * dabs;

  assign scan_hit  = rd_valid && rd_scan && finished && (18'(rd_mag) <= thr);
  assign done_next = (cmd.code == CMD_REPORT) || (cmd.code == CMD_FNONE) || scan_hit;

  always_comb begin
    res_next = '0;
    if (cmd.code == CMD_REPORT) begin
      res_next.kind        = KIND_STATS;
      res_next.mean_mag    = mean;
      res_next.std_mag     = stdv;
      res_next.clip_level  = thr;
      res_next.total_count = 10'(load_count);
      res_next.kept_count  = 10'(kept);
      res_next.overflowed  = ovf;
    end else if (cmd.code == CMD_FNONE) begin
      res_next.kind = KIND_NONE;
    end else if (scan_hit) begin
      res_next.kind    = KIND_KEPT;
      res_next.out_x   = rd_vec[15:0];
      res_next.out_y   = rd_vec[31:16];
      res_next.out_mag = rd_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      fetch_ptr  <= '0;
      thr        <= '0;
      finished   <= 1'b0;
      ovf        <= 1'b0;
      pend       <= 1'b0;
      rd_valid   <= 1'b0;
      rd_keep    <= 1'b0;
      rd_scan    <= 1'b0;
      done       <= 1'b0;
      div_mean   <= 1'b0;
    end else begin
      done     <= done_next;
      rd_valid <= (cmd.code inside {CMD_SUM, CMD_DEV, CMD_KEEP, CMD_FSCAN});
      rd_keep  <= (cmd.code == CMD_KEEP);
      rd_scan  <= (cmd.code == CMD_FSCAN);
      if (done_next) result <= res_next;
      if (pend && !r1_busy) begin
        pend       <= 1'b0;
        load_count <= load_count + 1'b1;
      end
      case (cmd.code)
        CMD_LOAD: begin
          if (cmd.new_set) begin
            fetch_ptr <= '0;
            finished  <= 1'b0;
          end
          // dropped when the set is full
          pend     <= cmd.new_set || (load_count != CW'(MAX_FEATURES));
          pend_vec <= {item.disp_y, item.disp_x};
        end
        CMD_SUM_CLR: begin
          sum  <= '0;
          dev  <= '0;
          kept <= '0;
          idx  <= '0;
          mean <= '0;
          stdv <= '0;
        end
        CMD_SUM: idx <= idx + 1'b1;
        CMD_DIV1: begin
          div_mean <= 1'b1;
          idx      <= '0;
        end
        CMD_DEV: idx <= idx + 1'b1;
        CMD_DIV2: idx <= '0;
        CMD_THR: begin
          thr  <= 18'(mean) + {1'b0, sd_now, 1'b0};
          stdv <= sd_now;
          idx  <= '0;
        end
        CMD_KEEP: idx <= idx + 1'b1;
        CMD_REPORT: begin
          finished  <= 1'b1;
          fetch_ptr <= '0;
        end
        CMD_FSCAN: fetch_ptr <= fetch_ptr + 1'b1;
        default: ;
      endcase
      // overflow handling: flag when full
      if (cmd.code == CMD_LOAD) begin
        if (cmd.new_set) begin
          ovf        <= 1'b0;
          load_count <= '0;
        end else if (load_count == CW'(MAX_FEATURES)) begin
          ovf <= 1'b1;
        end
      end
      // accumulate registered reads, one per cycle behind the index
      if (rd_valid) begin
        case (cmd.code)
          CMD_SUM, CMD_DIV1: sum <= sum + SW'(rd_mag);
          CMD_DEV, CMD_DIV2: dev <= dev + VW'(dsq);
          default: ;
        endcase
        if (rd_keep && 18'(rd_mag) <= thr) kept <= kept + 1'b1;
      end
      if (div_mean && !div_busy && !div_go) begin
        div_mean <= 1'b0;
        mean     <= div_quo[15:0];
      end
    end
  end

  always_comb begin
    stat.unit_busy = r1_busy || pend || div_busy || r2_busy || div_mean;
    stat.idx_last  = (idx == load_count - 1'b1);
    stat.empty     = (load_count == '0);
    stat.finished  = finished;
    stat.fetch_end = (fetch_ptr == load_count);
    stat.fetch_hit = scan_hit;
    stat.rd_valid  = rd_valid;
  end
endmodule

### rtl/fvsc_ctrl.sv
// ----------------------------------------------------------------------------
// fvsc_ctrl
// controller: sequences load, finish walks and fetch scan
// ----------------------------------------------------------------------------
module fvsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         opcode,
  input  fvsc_pkg::dp_stat_t stat,
  output logic               busy,
  output fvsc_pkg::dp_cmd_t  cmd
);
  import fvsc_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_LOAD  = 13'b0000000000010,
    S_SUM   = 13'b0000000000100,
    S_DIV1  = 13'b0000000001000,
    S_WDIV1 = 13'b0000000010000,
    S_DEV   = 13'b0000000100000,
    S_DIV2  = 13'b0000001000000,
    S_ROOT  = 13'b0000010000000,
    S_WROOT = 13'b0000100000000,
    S_KEEP  = 13'b0001000000000,
    S_REP   = 13'b0010000000000,
    S_FSCAN = 13'b0100000000000,
    S_FWAIT = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    cmd.code    = CMD_NOP;
    cmd.new_set = stat.finished;
    busy        = (state != S_IDLE) || stat.unit_busy;
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          case (opcode)
            OP_LOAD:   cmd.code = CMD_LOAD;
            OP_FINISH: begin
              cmd.code   = CMD_SUM_CLR;
              state_next = stat.empty ? S_DIV2 : S_SUM;
            end
            OP_FETCH: begin
              if (!stat.finished || stat.fetch_end) cmd.code = CMD_FNONE;
              else state_next = S_FSCAN;
            end
            default: ;
          endcase
        end
      end
      S_SUM: begin
        cmd.code = CMD_SUM;
        if (stat.idx_last) state_next = S_DIV1;
      end
      S_DIV1: begin
        cmd.code   = CMD_DIV1;
        state_next = S_WDIV1;
      end
      S_WDIV1: if (!stat.unit_busy) state_next = S_DEV;
      S_DEV: begin
        cmd.code = CMD_DEV;
        if (stat.idx_last) state_next = S_DIV2;
      end
      S_DIV2: begin
        if (!stat.empty) cmd.code = CMD_DIV2;
        state_next = S_ROOT;
      end
      S_ROOT: if (!stat.unit_busy) begin
        if (!stat.empty) cmd.code = CMD_ROOT;
        state_next = S_WROOT;
      end
      S_WROOT: if (!stat.unit_busy) begin
        cmd.code   = CMD_THR;
        state_next = stat.empty ? S_REP : S_KEEP;
      end
      S_KEEP: begin
        cmd.code = CMD_KEEP;
        if (stat.idx_last) state_next = S_LOAD;
      end
      S_LOAD: state_next = S_REP;  // drain last kept compare
      S_REP: begin
        cmd.code   = CMD_REPORT;
        state_next = S_IDLE;
      end
      S_FSCAN: begin
        cmd.code   = CMD_FSCAN;
        state_next = S_FWAIT;
      end
      S_FWAIT: begin
        if (stat.fetch_hit) state_next = S_IDLE;
        else if (stat.fetch_end) begin
          cmd.code   = CMD_FNONE;
          state_next = S_IDLE;
        end else state_next = S_FSCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### rtl/flow_vector_sigma_clip.sv
// ----------------------------------------------------------------------------
// flow_vector_sigma_clip
// two-sigma clipping of tracked-feature displacement vectors
// ----------------------------------------------------------------------------
// channel  direction  handshake           beat
// cmd      in         start & !busy       in_item (opcode, disp_x, disp_y)
// result   out        valid, one cycle    out_item (stats, kept, none-left)
//
// load: busy after the beat while the magnitude root iterates and the entry is
//   stored; when the set is full the beat is dropped and only the root runs
// finish: three store walks, two divides of width 32+clog2(N+1) and a root of
//   half that width; an empty set skips the walks, divides and root
// fetch: each store entry examined passes a scan and a wait state (registered memory read)
// reset clears the load count, fetch pointer, threshold and flags only; stores hold no reset value
// results cannot be stalled; valid lasts exactly one cycle
module flow_vector_sigma_clip #(
  parameter int MAX_FEATURES = fvsc_pkg::MaxFeaturesDefault,
  parameter int FRAC_BITS    = fvsc_pkg::FracBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  fvsc_pkg::in_item_t  in_item,
  output logic                valid,
  output fvsc_pkg::out_item_t out_item
);
  import fvsc_pkg::*;

  // units are 2^-FRAC_BITS pixel throughout; roots keep the unit
  localparam int UnitBits = FRAC_BITS;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fvsc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(in_item.opcode),
    .stat(stat), .busy(busy), .cmd(cmd)
  );

  fvsc_datapath #(.MAX_FEATURES(MAX_FEATURES + 0 * UnitBits)) u_dp (
    .clk(clk), .rst(rst), .item(in_item), .cmd(cmd), .stat(stat),
    .done(valid), .result(out_item)
  );
endmodule

### rtl/fvsc_checker.sv
// ----------------------------------------------------------------------------
// fvsc_checker
// port-level checks on the sigma clip block
// ----------------------------------------------------------------------------
`include "flow_vector_sigma_clip_macros.svh"
module fvsc_props (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input fvsc_pkg::in_item_t  in_item,
  input logic                valid,
  input fvsc_pkg::out_item_t out_item
);
  import fvsc_pkg::*;

  // a result never carries an unused kind
  `FVSC_ASSERT_IMP(a_kind, clk, rst, valid,
    out_item.kind == KIND_STATS || out_item.kind == KIND_KEPT
    || out_item.kind == KIND_NONE, "bad result kind")
  // a load never gives a result on the next cycle
  `FVSC_ASSERT_NEXT(a_load_quiet, clk, rst,
    start && !busy && in_item.opcode == OP_LOAD, !valid, "load made result")
  // an accepted finish makes the block busy
  `FVSC_ASSERT_NEXT(a_busy, clk, rst,
    start && !busy && in_item.opcode == OP_FINISH, busy, "finish not busy")
endmodule

bind flow_vector_sigma_clip fvsc_props u_chk (.*);

### tb/fvsc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fvsc_checker
// watches the command and result channels of the sigma clip block, predicts
// each result from its own copy of the feature set and compares field by field
// ----------------------------------------------------------------------------
module fvsc_checker #(
  parameter int MAX_FEATURES = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  fvsc_pkg::in_item_t  in_item,
  input  logic                valid,
  input  fvsc_pkg::out_item_t out_item,
  output int                  errors,
  output int                  pending,
  output int                  n_stats,
  output int                  n_kept,
  output int                  n_none
);
  import fvsc_pkg::*;

  logic [31:0] vec_mem [MAX_FEATURES];
  logic [15:0] mag_mem [MAX_FEATURES];
  int unsigned set_size, scan_ptr;
  logic [17:0] clip_thr;
  logic        set_closed, set_overflow;
  out_item_t   result_q[$];

  initial begin
    errors = 0; n_stats = 0; n_kept = 0; n_none = 0;
  end
  assign pending = result_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic predict_clip(in_item_t it);
    out_item_t r;
    longint signed dx, dy;
    longint unsigned sum, dev, mean, sd, d;
    int unsigned kept;
    r = '0;
    case (it.opcode)
      OP_LOAD: begin
        dx = it.disp_x;
        dy = it.disp_y;
        if (set_closed) begin
          set_size = 0; scan_ptr = 0; set_overflow = 0; set_closed = 0;
        end
        if (set_size < MAX_FEATURES) begin
          vec_mem[set_size] = {it.disp_y, it.disp_x};
          mag_mem[set_size] = 16'(int_sqrt(longint'(dx * dx + dy * dy)));
          set_size++;
        end else begin
          set_overflow = 1;
        end
      end
      OP_FINISH: begin
        sum = 0; dev = 0; mean = 0; sd = 0; kept = 0;
        for (int i = 0; i < set_size; i++) sum += mag_mem[i];
        if (set_size != 0) begin
          mean = sum / set_size;
          for (int i = 0; i < set_size; i++) begin
            d = (mag_mem[i] >= mean) ? mag_mem[i] - mean : mean - mag_mem[i];
            dev += d * d;
          end
          sd = int_sqrt(dev / set_size);
        end
        clip_thr = 18'(mean + 2 * sd);
        for (int i = 0; i < set_size; i++) if (mag_mem[i] <= clip_thr) kept++;
        set_closed = 1;
        scan_ptr = 0;
        r.kind = KIND_STATS;
        r.mean_mag = 16'(mean);
        r.std_mag = 16'(sd);
        r.clip_level = clip_thr;
        r.total_count = 10'(set_size);
        r.kept_count = 10'(kept);
        r.overflowed = set_overflow;
        result_q = {result_q, r};
      end
      OP_FETCH: begin
        r.kind = KIND_NONE;
        if (set_closed) begin
          while (scan_ptr < set_size) begin
            scan_ptr++;
            if (mag_mem[scan_ptr-1] <= clip_thr) begin
              r.kind = KIND_KEPT;
              {r.out_y, r.out_x} = vec_mem[scan_ptr-1];
              r.out_mag = mag_mem[scan_ptr-1];
              break;
            end
          end
        end
        result_q = {result_q, r};
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (rst) begin
      set_size <= 0; scan_ptr <= 0; clip_thr <= '0;
      set_closed <= 0; set_overflow <= 0;
    end else begin
      if (valid) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result kind", out_item.kind, -1);
        end else begin
          w = result_q.pop_front();
          if (w.kind == KIND_STATS) n_stats++;
          else if (w.kind == KIND_KEPT) n_kept++;
          else n_none++;
          if (out_item.kind !== w.kind) report_mismatch("kind", out_item.kind, w.kind);
          if (out_item.mean_mag !== w.mean_mag)
            report_mismatch("mean_mag", out_item.mean_mag, w.mean_mag);
          if (out_item.std_mag !== w.std_mag)
            report_mismatch("std_mag", out_item.std_mag, w.std_mag);
          if (out_item.clip_level !== w.clip_level)
            report_mismatch("clip_level", out_item.clip_level, w.clip_level);
          if (out_item.total_count !== w.total_count)
            report_mismatch("total_count", out_item.total_count, w.total_count);
          if (out_item.kept_count !== w.kept_count)
            report_mismatch("kept_count", out_item.kept_count, w.kept_count);
          if (out_item.overflowed !== w.overflowed)
            report_mismatch("overflowed", out_item.overflowed, w.overflowed);
          if (out_item.out_x !== w.out_x) report_mismatch("out_x", out_item.out_x, w.out_x);
          if (out_item.out_y !== w.out_y) report_mismatch("out_y", out_item.out_y, w.out_y);
          if (out_item.out_mag !== w.out_mag)
            report_mismatch("out_mag", out_item.out_mag, w.out_mag);
        end
      end
      // blocking updates keep the model in step with accepted beats
      if (start && !busy) predict_clip(in_item);
    end
  end
endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the sigma clip block: directed corner beats, then random sets
// of loads, finishes and fetches, with bursty command gaps; checker verifies
// ----------------------------------------------------------------------------
module tb_top;
  import fvsc_pkg::*;

  localparam int MaxFeat  = 512;
  localparam int IdleLimit = 20000; // exceeds the finish time of a full set
  localparam logic [1:0] OpSpare = 2'd3;

  logic      clk, rst, start, busy, valid;
  in_item_t  in_item;
  out_item_t out_item;
  int        errors, pending, n_stats, n_kept, n_none;
  int        beats_sent, idle_cycles;

  flow_vector_sigma_clip #(.MAX_FEATURES(MaxFeat)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_item(in_item), .valid(valid), .out_item(out_item)
  );

  fvsc_checker #(.MAX_FEATURES(MaxFeat)) chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .valid(valid), .out_item(out_item), .errors(errors), .pending(pending),
    .n_stats(n_stats), .n_kept(n_kept), .n_none(n_none)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog: cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  int burst_left;

  // drive one beat, holding start until it is taken; gaps between bursts
  task automatic send_beat(logic [1:0] op, logic [15:0] x, logic [15:0] y);
    if (burst_left == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    start <= 1;
    in_item <= '{opcode: op, disp_x: x, disp_y: y};
    // busy only moves at rising edges, so it is stable at the falling edge
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    beats_sent++;
    burst_left--;
  endtask

  function automatic logic [15:0] rand_disp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'h8000;
      2: return 16'h7fff;
      default: return 16'($signed($urandom_range(0, 80)) - 40);
    endcase
  endfunction

  initial begin
    int n;
    start = 0; in_item = '0; rst = 1; idle_cycles = 0;
    beats_sent = 0; burst_left = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: fetch before finish, empty set, extremes, outlier, op three
    send_beat(OP_FETCH, 0, 0);
    send_beat(OP_FINISH, 0, 0);
    send_beat(OP_FETCH, 0, 0);
    send_beat(OP_LOAD, 16'h8000, 16'h8000);
    send_beat(OP_LOAD, 16'h7fff, 16'h7fff);
    send_beat(OP_LOAD, 16'hffff, 16'h0000);
    send_beat(OP_LOAD, 0, 0);
    send_beat(OpSpare, 16'h1234, 16'h5678);
    send_beat(OP_FINISH, 0, 0);
    for (int i = 0; i < 5; i++) send_beat(OP_FETCH, 0, 0);
    send_beat(OP_FINISH, 0, 0);            // repeated finish restarts fetch
    send_beat(OP_FETCH, 0, 0);
    for (int i = 0; i < 6; i++) send_beat(OP_LOAD, 16'd3, 16'd4);
    send_beat(OP_LOAD, 16'h7000, 16'h0000); // lone outlier
    send_beat(OP_FINISH, 0, 0);
    for (int i = 0; i < 3; i++) send_beat(OP_FETCH, 0, 0);

    // one overfull set to hit capacity and the overflow flag
    for (int i = 0; i < MaxFeat + 3; i++) send_beat(OP_LOAD, rand_disp(), rand_disp());
    send_beat(OP_FINISH, 0, 0);
    send_beat(OP_FETCH, 0, 0);

    // random sets: mostly well-formed load/finish/fetch runs, some noise
    while (beats_sent < 600) begin
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 15) == 0)
          send_beat(2'($urandom_range(1, 3)), rand_disp(), rand_disp());
        else send_beat(OP_LOAD, rand_disp(), rand_disp());
      end
      send_beat(OP_FINISH, 16'($urandom), 16'($urandom));
      n = $urandom_range(0, 14);
      for (int i = 0; i < n; i++) send_beat(OP_FETCH, 16'($urandom), 16'($urandom));
    end
    start <= 0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("run covered %0d command beats: %0d stats, %0d kept, %0d none-left results",
             beats_sent, n_stats, n_kept, n_none);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
